/* hdl/sirs_pkg.sv */
package sirs_pkg;

  // Default width of the converted number.
  localparam int VALUE_BITS_DEF = 32;
  // Largest radix the alphabet may have.
  localparam int MAX_RADIX = 16;
  // Number of dividend bits handled by the divide slice in one cycle.
  localparam int STEP_BITS = 8;

  localparam int DIGIT_W = 4;
  localparam int SYM_W = 8;
  localparam int RADIX_W = 5;
  localparam int NUM_SYMS = 16;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  // Characters that may not appear in the alphabet.
  localparam logic [SYM_W-1:0] CHAR_PLUS = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [SYM_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [SYM_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_PREP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load_value;
    logic start_digit;
    logic div_step;
    logic put_sign;
    logic put_digit;
  } cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic idx_zero;
    logic quot_zero;
    logic cnt_zero;
    logic neg;
    logic out_free;
  } sts_t;

endpackage

/* hdl/sirs_ram.sv */
module sirs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sirs_ctrl.sv */
module sirs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sirs_pkg::sts_t    sts_i,
  output sirs_pkg::cmd_t    cmd_o
);

  sirs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sirs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sirs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sirs_pkg::ST_CHECK;
      end
      sirs_pkg::ST_CHECK: begin
        state_d = sts_i.alpha_ok ? sirs_pkg::ST_DIV : sirs_pkg::ST_IDLE;
      end
      sirs_pkg::ST_DIV: begin
        if (sts_i.idx_zero && sts_i.quot_zero) state_d = sirs_pkg::ST_PREP;
      end
      sirs_pkg::ST_PREP: begin
        if (!sts_i.neg || sts_i.out_free) state_d = sirs_pkg::ST_EMIT;
      end
      sirs_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.cnt_zero) state_d = sirs_pkg::ST_IDLE;
      end
      default: state_d = sirs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sirs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_value = in_valid_i;
      end
      sirs_pkg::ST_CHECK: cmd_o.start_digit = sts_i.alpha_ok;
      sirs_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      sirs_pkg::ST_PREP: cmd_o.put_sign = sts_i.neg && sts_i.out_free;
      sirs_pkg::ST_EMIT: cmd_o.put_digit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* hdl/sirs_dp.sv */
module sirs_dp #(
  parameter int VALUE_BITS = sirs_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic signed [VALUE_BITS-1:0]    value_i,
  input  logic                            cfg_we_i,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sirs_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sirs_pkg::SYM_W-1:0]      symbol_o,
  output logic                            final_res_o,
  input  sirs_pkg::cmd_t                  cmd_i,
  output sirs_pkg::sts_t                  sts_o
);

  localparam int STEP = sirs_pkg::STEP_BITS;
  localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
  localparam int PAD_W = CHUNKS * STEP;
  localparam int IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int DW = sirs_pkg::DIGIT_W;
  localparam int RW = sirs_pkg::RADIX_W;
  localparam int SW = sirs_pkg::SYM_W;

  // Configuration registers.
  logic [RW-1:0]               alpha_size_q;
  logic [sirs_pkg::CFG_W-1:0]  sym_low_q;
  logic [sirs_pkg::CFG_W-1:0]  sym_high_q;
  logic [SW-1:0]               sym_tab [sirs_pkg::NUM_SYMS];
  logic                        alpha_bad;

  // Division state.
  logic [PAD_W-1:0]  work_q, work_nx;
  logic [DW-1:0]     rem_q, rem_nx;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q;
  logic [STEP-1:0]   chunk, qchunk;
  logic [RW-1:0]     trial;
  logic [RW-1:0]     diff;
  logic [VALUE_BITS-1:0] value_u, mag_in;

  // Output register.
  logic              out_valid_q;
  logic [SW-1:0]     sym_q;
  logic              final_q;
  logic              out_free;

  // Digit buffer.
  logic              ram_we;
  logic [CNT_W-1:0]  ram_raddr;
  logic [DW-1:0]     ram_rdata;

  function automatic logic [IDX_W-1:0] top_chunk(input logic [PAD_W-1:0] w);
    logic [IDX_W-1:0] hi;
    hi = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (w[c*STEP +: STEP] != '0) hi = IDX_W'(c);
    end
    return hi;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_size_q <= '0;
      sym_low_q <= '0;
      sym_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sirs_pkg::CFG_ALPHABET_SIZE: alpha_size_q <= cfg_wdata_i[RW-1:0];
        sirs_pkg::CFG_SYMBOLS_LOW: sym_low_q <= cfg_wdata_i;
        sirs_pkg::CFG_SYMBOLS_HIGH: sym_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < sirs_pkg::NUM_SYMS / 2; i++) begin
      sym_tab[i] = sym_low_q[i*SW +: SW];
      sym_tab[i + sirs_pkg::NUM_SYMS / 2] = sym_high_q[i*SW +: SW];
    end
  end

  // The alphabet is rejected when its size is out of range, when a symbol in use
  // is a sign, blank, control whitespace or NUL, or when two symbols in use match.
  always_comb begin
    alpha_bad = (alpha_size_q < sirs_pkg::MIN_RADIX) ||
                (alpha_size_q > RW'(sirs_pkg::MAX_RADIX));
    for (int i = 0; i < sirs_pkg::NUM_SYMS; i++) begin
      if (RW'(i) < alpha_size_q) begin
        if (sym_tab[i] == sirs_pkg::CHAR_PLUS || sym_tab[i] == sirs_pkg::CHAR_MINUS ||
            sym_tab[i] == sirs_pkg::CHAR_SPACE || sym_tab[i] == sirs_pkg::CHAR_NUL ||
            (sym_tab[i] >= sirs_pkg::CHAR_TAB && sym_tab[i] <= sirs_pkg::CHAR_CR)) begin
          alpha_bad = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (sym_tab[j] == sym_tab[i]) alpha_bad = 1'b1;
        end
      end
    end
  end

  assign value_u = value_i;
  assign mag_in = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;

  // One slice of restoring division: STEP quotient bits of the current chunk.
  always_comb begin
    chunk = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (idx_q == IDX_W'(c)) chunk = work_q[c*STEP +: STEP];
    end
    rem_nx = rem_q;
    qchunk = '0;
    trial = '0;
    diff = '0;
    for (int b = STEP - 1; b >= 0; b--) begin
      trial = {rem_nx, chunk[b]};
      diff = trial - alpha_size_q;
      if (trial >= alpha_size_q) begin
        qchunk[b] = 1'b1;
        rem_nx = diff[DW-1:0];
      end else begin
        rem_nx = trial[DW-1:0];
      end
    end
    work_nx = work_q;
    for (int c = 0; c < CHUNKS; c++) begin
      if (idx_q == IDX_W'(c)) work_nx[c*STEP +: STEP] = qchunk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      rem_q <= '0;
      idx_q <= '0;
      cnt_q <= '0;
      neg_q <= 1'b0;
    end else begin
      if (cmd_i.load_value) begin
        work_q <= PAD_W'(mag_in);
        neg_q <= value_u[VALUE_BITS-1];
      end
      if (cmd_i.start_digit) begin
        idx_q <= top_chunk(work_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        work_q <= work_nx;
        if (idx_q == '0) begin
          // Digit done; the next one starts at the top nonzero chunk of the quotient.
          rem_q <= '0;
          idx_q <= top_chunk(work_nx);
          if (work_nx != '0) cnt_q <= cnt_q + CNT_W'(1);
        end else begin
          rem_q <= rem_nx;
          idx_q <= idx_q - IDX_W'(1);
        end
      end
      if (cmd_i.put_digit) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign ram_we = cmd_i.div_step && (idx_q == '0);
  // While a digit leaves, the next lower digit is fetched; otherwise the current one is held.
  assign ram_raddr = cmd_i.put_digit ? (cnt_q - CNT_W'(1)) : cnt_q;

  sirs_ram #(
    .WIDTH (DW),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (rem_nx),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.put_sign || cmd_i.put_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_sign) begin
      sym_q <= sirs_pkg::CHAR_MINUS;
      final_q <= 1'b0;
    end else if (cmd_i.put_digit) begin
      sym_q <= sym_tab[ram_rdata];
      final_q <= (cnt_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o = sym_q;
  assign final_res_o = final_q;

  assign sts_o.alpha_ok = !alpha_bad;
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.quot_zero = (work_nx == '0);
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.neg = neg_q;
  assign sts_o.out_free = out_free;

endmodule

/* hdl/signed_integer_to_radix_symbols.sv */
// After a request the control checks the alphabet, then divides out each digit over the 8-bit
// slices of the remaining quotient; a hand-over state puts out the sign of a negative number,
// then the digits leave most significant first. One number at a time: a new request is taken
// once the last digit is loaded into the output register or the alphabet check rejects it.
// Reset clears the configuration and the control.
module signed_integer_to_radix_symbols #(
  parameter int VALUE_BITS = sirs_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [VALUE_BITS-1:0]    value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sirs_pkg::SYM_W-1:0]      symbol_o,
  output logic                            final_res_o,
  input  logic                            cfg_we_i,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sirs_pkg::CFG_W-1:0]      cfg_wdata_i
);

  sirs_pkg::cmd_t cmd;
  sirs_pkg::sts_t sts;

  sirs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sirs_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .symbol_o    (symbol_o),
    .final_res_o (final_res_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // A new request is only taken once no non-final symbol of the previous number is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_valid_o) |-> final_res_o)
    else $error("request taken while a non-final symbol is pending");

  // After the last digit leaves, the block is ready for the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.put_digit && sts.cnt_zero) |=> in_ready_o)
    else $error("block not ready after the final symbol");

  // Finishing the division never returns straight to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step && sts.idx_zero && sts.quot_zero) |=> !in_ready_o)
    else $error("division ended without emitting symbols");

  // Loading a symbol never overlaps dividing or loading a new value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.put_sign || cmd.put_digit) |-> !(cmd.div_step || cmd.load_value))
    else $error("output load during division");

endmodule

/* dv/sirs_checker.sv */
module sirs_checker #(
  parameter int VALUE_BITS = sirs_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic signed [VALUE_BITS-1:0]    value_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [sirs_pkg::SYM_W-1:0]      symbol_i,
  input  logic                            final_res_i,
  input  logic                            cfg_we_i,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sirs_pkg::CFG_W-1:0]      cfg_wdata_i,
  output int                              errors_o,
  output int                              symbols_left_o
);
  import sirs_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             is_last;
  } sym_rec_t;

  // Shadow copy of the configuration registers.
  logic [RADIX_W-1:0] radix_q = '0;
  logic [CFG_W-1:0]   syms_low_q = '0;
  logic [CFG_W-1:0]   syms_high_q = '0;

  sym_rec_t expected_syms[$];

  function automatic logic [SYM_W-1:0] digit_symbol(input int d);
    if (d < 8) begin
      return syms_low_q[8*d +: 8];
    end
    return syms_high_q[8*(d-8) +: 8];
  endfunction

  function automatic bit alphabet_usable();
    int n;
    logic [SYM_W-1:0] c;
    n = radix_q;
    if (n < MIN_RADIX || n > MAX_RADIX) begin
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      c = digit_symbol(i);
      if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE || c == CHAR_NUL ||
          (c >= CHAR_TAB && c <= CHAR_CR)) begin
        return 1'b0;
      end
      for (int j = 0; j < i; j++) begin
        if (digit_symbol(j) == c) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // Digits come out least significant first and are queued in reverse.
  task automatic predict_symbols(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] radix;
    logic [DIGIT_W-1:0]    digits[$];
    sym_rec_t              rec;
    if (!alphabet_usable()) begin
      return;
    end
    radix = VALUE_BITS'(radix_q);
    mag = v[VALUE_BITS-1] ? -v : v;
    do begin
      digits.push_back(DIGIT_W'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (v[VALUE_BITS-1]) begin
      rec.symbol = CHAR_MINUS;
      rec.is_last = 1'b0;
      expected_syms.push_back(rec);
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      rec.symbol = digit_symbol(digits[k]);
      rec.is_last = (k == 0);
      expected_syms.push_back(rec);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sym_rec_t want;
    if (!rst_ni) begin
      radix_q = '0;
      syms_low_q = '0;
      syms_high_q = '0;
      expected_syms.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_syms.size() == 0) begin
          report_mismatch($sformatf("symbol 0x%02h arrived with none expected", symbol_i));
        end else begin
          want = expected_syms.pop_front();
          if (symbol_i !== want.symbol) begin
            report_mismatch($sformatf("symbol 0x%02h, expected 0x%02h",
                                      symbol_i, want.symbol));
          end
          if (final_res_i !== want.is_last) begin
            report_mismatch($sformatf("final flag %b on symbol 0x%02h, expected %b",
                                      final_res_i, symbol_i, want.is_last));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ALPHABET_SIZE: begin
            radix_q = cfg_wdata_i[RADIX_W-1:0];
          end
          CFG_SYMBOLS_LOW: begin
            syms_low_q = cfg_wdata_i;
          end
          CFG_SYMBOLS_HIGH: begin
            syms_high_q = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_symbols(value_i);
      end
    end
    symbols_left_o = expected_syms.size();
  end

endmodule

/* dv/testbench.sv */
module testbench;
  import sirs_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int LATENCY_GUARD = 150;
  localparam int STALL_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam string HEX_CHARS = "0123456789ABCDEF";

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [VB-1:0] value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [SYM_W-1:0]     symbol_o;
  logic                 final_res_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  int mismatches;
  int symbols_left;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_len = 0;
  int cur_radix = 0;
  int quiet_cycles = 0;

  signed_integer_to_radix_symbols #(
    .VALUE_BITS(VB)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .symbol_o   (symbol_o),
    .final_res_o(final_res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  sirs_checker #(
    .VALUE_BITS(VB)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_i      (symbol_o),
    .final_res_i   (final_res_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .errors_o      (mismatches),
    .symbols_left_o(symbols_left)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        hold_left = hold_off_len;
        hold_off_len = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit forbidden_symbol(input logic [SYM_W-1:0] c);
    return c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE || c == CHAR_NUL ||
           (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic [SYM_W-1:0] pick_forbidden();
    case ($urandom_range(3))
      0: return CHAR_PLUS;
      1: return CHAR_MINUS;
      2: return CHAR_SPACE;
      default: return $urandom_range(1) ? CHAR_NUL : SYM_W'($urandom_range(CHAR_TAB, CHAR_CR));
    endcase
  endfunction

  // Register writes leave the write enable high; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_alphabet(input logic [RADIX_W-1:0] size, input logic [SYM_W-1:0] syms[16]);
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = syms[i];
      hi[8*i +: 8] = syms[8+i];
    end
    // Bits above the size field carry noise that must be dropped.
    write_reg(CFG_ALPHABET_SIZE, {32'($urandom), 27'($urandom), size});
    write_reg(CFG_SYMBOLS_LOW, lo);
    write_reg(CFG_SYMBOLS_HIGH, hi);
    cfg_we_i <= 1'b0;
    cur_radix = size;
  endtask

  task automatic send_value(input logic [VB-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (symbols_left != 0);
    @(posedge clk_i);
  endtask

  // An item with an unusable alphabet yields nothing, so the block may still
  // be busy once the queue is empty; give it the worst-case latency.
  task automatic finish_group();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (LATENCY_GUARD) @(posedge clk_i);
  endtask

  function automatic logic [VB-1:0] random_value();
    longint p;
    int r;
    logic [VB-1:0] v;
    r = (cur_radix >= 2 && cur_radix <= MAX_RADIX) ? cur_radix : 10;
    case ($urandom_range(7))
      0, 1, 2: v = $urandom;
      3: v = $urandom_range(0, 2 * r * r) - r * r;
      4: begin
        p = 1;
        repeat ($urandom_range(1, 31)) begin
          if (p * r <= 64'sd2147483648) begin
            p = p * r;
          end
        end
        v = VB'(p - $urandom_range(1));
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
      5: begin
        case ($urandom_range(4))
          0: v = {1'b1, {(VB-1){1'b0}}};
          1: v = {1'b0, {(VB-1){1'b1}}};
          2: v = '0;
          3: v = '1;
          default: v = 1;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  task automatic random_alphabet();
    logic [SYM_W-1:0]   syms[16];
    logic [255:0]       used;
    logic [SYM_W-1:0]   c;
    logic [RADIX_W-1:0] size;
    int j;
    case ($urandom_range(3))
      0: size = 2;
      1: size = 16;
      default: size = $urandom_range(2, 16);
    endcase
    used = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < size) begin
        do c = $urandom_range(255); while (forbidden_symbol(c) || used[c]);
        used[c] = 1'b1;
        syms[i] = c;
      end else begin
        syms[i] = $urandom_range(255);
      end
    end
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: size = $urandom_range(1) ? RADIX_W'($urandom_range(1)) : RADIX_W'($urandom_range(17, 31));
        1: syms[$urandom_range(size - 1)] = pick_forbidden();
        default: begin
          j = $urandom_range(1, size - 1);
          syms[j] = syms[$urandom_range(j - 1)];
        end
      endcase
    end
    set_alphabet(size, syms);
  endtask

  task automatic send_batch(input int n, input int hold_at, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) begin
        hold_off_len = 400;
      end
      if (i == pause_at) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      send_value(random_value());
    end
  endtask

  initial begin
    logic [SYM_W-1:0] hex_syms[16];
    logic [SYM_W-1:0] bad_syms[16];
    logic [SYM_W-1:0] bin_syms[16];
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 51, 0, 10};
    recv_pcts = '{0, 0, 51, 10};
    for (int i = 0; i < 16; i++) begin
      hex_syms[i] = HEX_CHARS[i];
      bin_syms[i] = 8'hFF;
    end
    bin_syms[0] = "x";
    bin_syms[1] = "y";

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the alphabet is empty, so nothing comes out.
    send_value($urandom);
    finish_group();

    write_reg(CFG_UNUSED, {32'($urandom), 32'($urandom)});
    set_alphabet(10, hex_syms);
    send_value(0);
    send_value(7);
    send_value(-1);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(-1000000000);
    finish_group();

    set_alphabet(16, hex_syms);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFF0);
    send_value(15);
    send_value(32'h7FFF_FFFF);
    finish_group();

    // Radix two: the most negative value gives a sign and 32 digits.
    set_alphabet(2, bin_syms);
    send_value(32'h8000_0000);
    send_value(32'h5555_5555);
    send_value(0);
    finish_group();

    // Unusable alphabets: bad sizes, forbidden characters, a repeated symbol.
    set_alphabet(1, hex_syms);
    send_value($urandom);
    finish_group();
    set_alphabet(17, hex_syms);
    send_value($urandom);
    finish_group();
    set_alphabet(31, hex_syms);
    send_value($urandom);
    finish_group();
    for (int k = 0; k < 7; k++) begin
      bad_syms = hex_syms;
      case (k)
        0: bad_syms[3] = CHAR_PLUS;
        1: bad_syms[0] = CHAR_MINUS;
        2: bad_syms[9] = CHAR_SPACE;
        3: bad_syms[15] = CHAR_TAB;
        4: bad_syms[12] = CHAR_CR;
        5: bad_syms[6] = CHAR_NUL;
        default: bad_syms[15] = bad_syms[0];
      endcase
      set_alphabet(16, bad_syms);
      send_value($urandom);
      finish_group();
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int c = 0; c < 4; c++) begin
        random_alphabet();
        send_batch(20, (ph == 0 && c == 1) ? 5 : -1, (ph == 1 && c == 2) ? 10 : -1);
        finish_group();
      end
    end

    @(negedge clk_i);
    if (mismatches == 0 && symbols_left == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/sirs_pkg.sv
hdl/sirs_ram.sv
hdl/sirs_ctrl.sv
hdl/sirs_dp.sv
hdl/signed_integer_to_radix_symbols.sv
dv/sirs_checker.sv
dv/testbench.sv
